// ----- design/dui_pkg.sv -----
// Shared types and constants of the def/use interval pruner.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dui_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 24;
	localparam int LEN_W   = 13;
	localparam int WIDTH_W = 4;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] MODE_INSTR  = 2'd0;
	localparam logic [1:0] MODE_ACCESS = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INSTR_LIMIT   = 2'd2;

	localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd4096;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 24'hFFFFFF;

	typedef struct packed {
		logic [COUNT_W-1:0] interval_start;
		logic [COUNT_W-1:0] interval_end;
		logic [ADDR_W-1:0]  end_ip;
		logic [ADDR_W-1:0]  byte_address;
		logic               needs_experiment;
	} result_t;

	typedef struct packed {
		logic               live;
		logic               emit;
		logic               need;
		logic [COUNT_W-1:0] ending;
		logic [COUNT_W-1:0] next_start;
	} eval_t;

	typedef struct packed {
		logic push;
		logic finish;
	} buf_cmd_t;

endpackage

`default_nettype wire

// ----- design/dui_start_ram.sv -----
// Interval start table: one write port and one read port, registered read data.
// Depends on dui_pkg for the entry width.
`default_nettype none

module dui_start_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [dui_pkg::COUNT_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [dui_pkg::COUNT_W-1:0] rdata
);

	logic [dui_pkg::COUNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/dui_byte_unit.sv -----
// Shared per-byte unit: window test of one byte address and the start/count
// comparison that decides emission and the new start. Depends on dui_pkg.
`default_nettype none

module dui_byte_unit #(
	parameter int WINDOW_BYTES = 4096,
	parameter int SLOT_W       = 12
) (
	input  wire logic [dui_pkg::ADDR_W-1:0]  byte_addr,
	input  wire logic [dui_pkg::ADDR_W-1:0]  base,
	input  wire logic [dui_pkg::LEN_W-1:0]   len,
	input  wire logic [dui_pkg::COUNT_W-1:0] start,
	input  wire logic [dui_pkg::COUNT_W-1:0] count,
	input  wire logic                        flush,
	input  wire logic [1:0]                  kind,
	output logic                             in_win,
	output logic      [SLOT_W-1:0]           slot,
	output dui_pkg::eval_t                   eval
);

	logic [dui_pkg::ADDR_W-1:0] off;
	logic [dui_pkg::ADDR_W-1:0] eff_len;

	always_comb begin
		off     = byte_addr - base;
		// The length register may exceed the table; the table size bounds it.
		eff_len = (32'(len) > 32'(WINDOW_BYTES)) ? 32'(WINDOW_BYTES) : 32'(len);
		in_win  = off < eff_len;
		slot    = off[SLOT_W-1:0];
	end

	always_comb begin
		if (flush) begin
			eval.live       = start < count;
			eval.emit       = start < count;
			eval.need       = 1'b0;
			eval.ending     = count - 24'd1;
			eval.next_start = count;
		end else begin
			eval.live       = start <= count;
			eval.emit       = (start <= count) &&
				(kind == dui_pkg::KIND_READ || kind == dui_pkg::KIND_WRITE);
			eval.need       = kind == dui_pkg::KIND_READ;
			eval.ending     = count;
			eval.next_start = count + 24'd1;
		end
	end

endmodule

`default_nettype wire

// ----- design/dui_result_buf.sv -----
// Result buffer: holds the newest result until it is known whether it is the
// last one of its event, and an output register towards the receiver. Uses dui_pkg.
`default_nettype none

module dui_result_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dui_pkg::buf_cmd_t  cmd,
	input  wire dui_pkg::result_t   res,
	output logic                    room,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output dui_pkg::result_t        out_res,
	output logic                    out_last
);

	logic             pend_vq;
	logic             out_vq;
	dui_pkg::result_t pend_q;
	dui_pkg::result_t out_q;
	logic             out_last_q;
	logic             move;

	// The pending result can always advance when the output register frees up.
	assign room      = !pend_vq || !out_vq || !out_stall;
	assign move      = (cmd.push || cmd.finish) && pend_vq;
	assign out_valid = out_vq;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vq <= 1'b0;
			out_vq  <= 1'b0;
		end else begin
			out_vq <= move || (out_vq && out_stall);
			if (cmd.push) begin
				pend_vq <= 1'b1;
			end else if (cmd.finish) begin
				pend_vq <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_q <= res;
		end
		if (move) begin
			out_q      <= pend_q;
			out_last_q <= cmd.finish;
		end
	end

`ifndef SYNTHESIS
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.finish))
		else $error("push and finish issued together");
	a_cmd_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.finish) |-> room)
		else $error("buffer command issued without room");
	a_finish_drains: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !pend_vq)
		else $error("pending result left after finish");
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (pend_vq && out_vq == ($past(pend_vq) || $past(out_vq && out_stall))))
		else $error("push lost a result");
`endif

endmodule

`default_nettype wire

// ----- design/def_use_interval_pruner.sv -----
// Def/use interval pruner over a memory trace. Sequencer and table around one
// shared per-byte unit; depends on dui_pkg, dui_start_ram, dui_byte_unit and
// dui_result_buf.
//
// Input channel (in_valid/in_stall): one trace event per transfer. The block
// raises in_stall while it works on an event. An instruction event, an
// instruction or access event past the instruction limit, the unused mode or a
// zero-width access is handled in the idle state. A memory access reads the
// table for each byte, then evaluates and writes back each byte inside the
// window, then closes the event; a flush does the same for its one byte.
// Output channel (out_valid/out_stall): one interval per transfer, with last
// set on the final interval of an event. A result is held in the pending
// register until the next one is known; the output register lets the next event
// be taken while the final result still waits. A stalled receiver holds the
// sequencer only when both result registers are full. Configuration must be
// written only while the block idles; the block itself does not enforce this.
// Reset clears the start table in a pass over every slot, during which no event
// is taken; configuration writes are accepted throughout.
`default_nettype none

module def_use_interval_pruner #(
	parameter int WINDOW_BYTES     = 4096,
	parameter int MAX_ACCESS_BYTES = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [dui_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dui_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          mode,
	input  wire logic [dui_pkg::ADDR_W-1:0]          instr_ip,
	input  wire logic [dui_pkg::ADDR_W-1:0]          mem_addr,
	input  wire logic [dui_pkg::WIDTH_W-1:0]         access_width,
	input  wire logic [1:0]                          access_kind,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [dui_pkg::COUNT_W-1:0]         interval_start,
	output logic      [dui_pkg::COUNT_W-1:0]         interval_end,
	output logic      [dui_pkg::ADDR_W-1:0]          end_ip,
	output logic      [dui_pkg::ADDR_W-1:0]          byte_address,
	output logic                                     needs_experiment,
	output logic                                     last
);

	localparam int SLOT_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
	localparam int BCNT_W = $clog2(MAX_ACCESS_BYTES + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [SLOT_W-1:0]           clr_q;
	logic [dui_pkg::ADDR_W-1:0]  base_q;
	logic [dui_pkg::LEN_W-1:0]   len_q;
	logic [dui_pkg::COUNT_W-1:0] limit_q;
	logic [dui_pkg::COUNT_W-1:0] count_q;
	logic [dui_pkg::ADDR_W-1:0]  ip_q;
	logic [BCNT_W-1:0]           idx_q;

	logic [dui_pkg::ADDR_W-1:0]  addr_q;
	logic [1:0]                  kind_q;
	logic                        flush_q;
	logic [BCNT_W-1:0]           nbytes_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [dui_pkg::ADDR_W-1:0]  baddr_q;

	logic                        accept;
	logic                        limit_hit;
	logic [BCNT_W-1:0]           nbytes_in;
	logic                        last_byte;
	logic [dui_pkg::ADDR_W-1:0]  cur_addr;
	logic                        in_win;
	logic [SLOT_W-1:0]           slot;
	dui_pkg::eval_t              eval;
	logic [dui_pkg::COUNT_W-1:0] rd_start;

	logic                        ram_we;
	logic [SLOT_W-1:0]           ram_waddr;
	logic [dui_pkg::COUNT_W-1:0] ram_wdata;
	logic                        ram_re;

	dui_pkg::buf_cmd_t           cmd;
	dui_pkg::result_t            res;
	dui_pkg::result_t            out_res;
	logic                        room;

	assign in_stall  = state_q != ST_IDLE;
	assign accept    = in_valid && !in_stall;
	assign limit_hit = count_q >= limit_q;
	assign nbytes_in = (32'(access_width) > 32'(MAX_ACCESS_BYTES)) ?
		BCNT_W'(MAX_ACCESS_BYTES) : BCNT_W'(access_width);
	assign last_byte = (idx_q + BCNT_W'(1)) == nbytes_q;
	assign cur_addr  = addr_q + 32'(idx_q);

	dui_byte_unit #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.SLOT_W      (SLOT_W)
	) u_byte (
		.byte_addr(cur_addr),
		.base     (base_q),
		.len      (len_q),
		.start    (rd_start),
		.count    (count_q),
		.flush    (flush_q),
		.kind     (kind_q),
		.in_win   (in_win),
		.slot     (slot),
		.eval     (eval)
	);

	dui_start_ram #(
		.DEPTH(WINDOW_BYTES),
		.AW   (SLOT_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(slot),
		.rdata(rd_start)
	);

	always_comb begin
		ram_re     = (state_q == ST_RD) && in_win;
		cmd.push   = (state_q == ST_EV) && eval.emit && room;
		cmd.finish = (state_q == ST_FIN) && room;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_EV) && eval.live && (room || !eval.emit);
			ram_waddr = slot_q;
			ram_wdata = eval.next_start;
		end
	end

	always_comb begin
		res.interval_start   = rd_start;
		res.interval_end     = eval.ending;
		res.end_ip           = flush_q ? '0 : ip_q;
		res.byte_address     = baddr_q;
		res.needs_experiment = eval.need;
	end

	dui_result_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res),
		.out_last (last)
	);

	assign interval_start   = out_res.interval_start;
	assign interval_end     = out_res.interval_end;
	assign end_ip           = out_res.end_ip;
	assign byte_address     = out_res.byte_address;
	assign needs_experiment = out_res.needs_experiment;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			len_q   <= dui_pkg::LEN_RESET;
			limit_q <= dui_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dui_pkg::CFG_REGION_BASE:   base_q  <= cfg_data;
				dui_pkg::CFG_REGION_LENGTH: len_q   <= cfg_data[dui_pkg::LEN_W-1:0];
				dui_pkg::CFG_INSTR_LIMIT:   limit_q <= cfg_data[dui_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			ip_q    <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(WINDOW_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (mode == dui_pkg::MODE_FLUSH) begin
							state_q <= ST_RD;
						end else if (!limit_hit && mode == dui_pkg::MODE_INSTR) begin
							count_q <= count_q + 24'd1;
							ip_q    <= instr_ip;
						end else if (!limit_hit && mode == dui_pkg::MODE_ACCESS &&
							nbytes_in != '0) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (in_win) begin
						state_q <= ST_EV;
					end else if (last_byte) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + BCNT_W'(1);
					end
				end
				ST_EV: begin
					// A result that cannot be taken yet keeps the byte here.
					if (room || !eval.emit) begin
						if (last_byte) begin
							state_q <= ST_FIN;
						end else begin
							idx_q   <= idx_q + BCNT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_FIN: begin
					if (room) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= mem_addr;
			kind_q  <= access_kind;
			flush_q <= mode == dui_pkg::MODE_FLUSH;
			// A flush touches exactly the one named byte.
			nbytes_q <= (mode == dui_pkg::MODE_FLUSH) ? BCNT_W'(1) : nbytes_in;
		end
		if (state_q == ST_RD) begin
			slot_q  <= slot;
			baddr_q <= cur_addr;
		end
	end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of def_use_interval_pruner: trace events go in on the input
// channel and every emitted interval is checked by a scoreboard with its own state.
// Depends on dui_pkg and the def_use_interval_pruner RTL.

module testbench;

	localparam int WINDOW_BYTES     = 4096;
	localparam int MAX_ACCESS_BYTES = 8;

	typedef logic [1:0]                    code_t;
	typedef logic [dui_pkg::WIDTH_W-1:0]   width_t;
	typedef logic [dui_pkg::ADDR_W-1:0]    addr_t;
	typedef logic [dui_pkg::CFG_IDX_W-1:0] index_t;
	typedef logic [dui_pkg::CFG_W-1:0]     word_t;

	localparam code_t  MODE_SPARE = 2'd3;
	localparam code_t  KIND_OTHER = 2'd2;
	localparam code_t  KIND_SPARE = 2'd3;
	localparam index_t CFG_SPARE  = 2'd3;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_EVENTS  = 70;
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [dui_pkg::COUNT_W-1:0] start_n;
		logic [dui_pkg::COUNT_W-1:0] end_n;
		logic [dui_pkg::ADDR_W-1:0]  ip;
		logic [dui_pkg::ADDR_W-1:0]  addr;
		logic                        need;
		logic                        is_last;
	} interval_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_style_t;

	class interval_scoreboard;
		bit [dui_pkg::COUNT_W-1:0] instr_count;
		bit [dui_pkg::ADDR_W-1:0]  current_ip;
		bit [dui_pkg::COUNT_W-1:0] starts [WINDOW_BYTES];
		bit [dui_pkg::ADDR_W-1:0]  region_base;
		bit [dui_pkg::LEN_W-1:0]   region_length;
		bit [dui_pkg::COUNT_W-1:0] instr_limit;
		interval_t                 pending[$];
		int                        errors;

		function new();
			region_length = dui_pkg::LEN_RESET;
			instr_limit = dui_pkg::LIMIT_RESET;
		endfunction

		function void write_register(index_t idx, word_t data);
			case (idx)
			dui_pkg::CFG_REGION_BASE: region_base = data;
			dui_pkg::CFG_REGION_LENGTH: region_length = data[dui_pkg::LEN_W-1:0];
			dui_pkg::CFG_INSTR_LIMIT: instr_limit = data[dui_pkg::COUNT_W-1:0];
			default: ;
			endcase
		endfunction

		function void append(interval_t v);
			pending.insert(pending.size(), v);
		endfunction

		// The window length saturates at the table size; offsets wrap modulo 2^32.
		function bit watched(bit [dui_pkg::ADDR_W-1:0] a, output int slot);
			bit [dui_pkg::ADDR_W-1:0] off;
			int span;
			off = a - region_base;
			span = (region_length > WINDOW_BYTES) ? WINDOW_BYTES : int'(region_length);
			if (off >= span)
				return 1'b0;
			slot = int'(off);
			return 1'b1;
		endfunction

		function void note_event(code_t m, addr_t ip, addr_t addr, width_t width, code_t kind);
			int slot;
			int bytes;
			int first;
			bit [dui_pkg::ADDR_W-1:0] a;
			// A flush is honoured even past the instruction limit.
			if (m == dui_pkg::MODE_FLUSH) begin
				if (watched(addr, slot) && starts[slot] < instr_count) begin
					append(interval_t'{starts[slot], instr_count - 1'b1, '0, addr,
						1'b0, 1'b1});
					starts[slot] = instr_count;
				end
				return;
			end
			if (instr_count >= instr_limit)
				return;
			if (m == dui_pkg::MODE_INSTR) begin
				instr_count++;
				current_ip = ip;
			end else if (m == dui_pkg::MODE_ACCESS) begin
				first = pending.size();
				bytes = (width > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(width);
				for (int i = 0; i < bytes; i++) begin
					a = addr + i;
					if (!watched(a, slot) || starts[slot] > instr_count)
						continue;
					if (kind == dui_pkg::KIND_READ || kind == dui_pkg::KIND_WRITE)
						append(interval_t'{starts[slot], instr_count, current_ip, a,
							kind == dui_pkg::KIND_READ, 1'b0});
					starts[slot] = instr_count + 1'b1;
				end
				if (pending.size() > first)
					pending[pending.size() - 1].is_last = 1'b1;
			end
		endfunction

		function string describe(interval_t v);
			return $sformatf("start %0d end %0d ip %h byte %h need %b last %b",
				v.start_n, v.end_n, v.ip, v.addr, v.need, v.is_last);
		endfunction

		function void check_interval(interval_t got);
			interval_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected interval: %s", describe(got));
				return;
			end
			want = pending.pop_front();
			if (got.start_n !== want.start_n || got.end_n !== want.end_n || got.ip !== want.ip ||
					got.addr !== want.addr || got.need !== want.need ||
					got.is_last !== want.is_last) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("interval mismatch, expected: %s", describe(want));
					$display("                     actual: %s", describe(got));
				end
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	index_t                        cfg_index = '0;
	word_t                         cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	code_t                         mode = dui_pkg::MODE_INSTR;
	addr_t                         instr_ip = '0;
	addr_t                         mem_addr = '0;
	width_t                        access_width = '0;
	code_t                         access_kind = dui_pkg::KIND_READ;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [dui_pkg::COUNT_W-1:0]   interval_start;
	logic [dui_pkg::COUNT_W-1:0]   interval_end;
	addr_t                         end_ip;
	addr_t                         byte_address;
	logic                          needs_experiment;
	logic                          last;

	interval_scoreboard sb = new();
	int        burst_left = 0;
	int        cycle_count = 0;
	int        rx_cycle = 0;
	rx_style_t rx_style = RX_FREE;

	def_use_interval_pruner #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.instr_ip(instr_ip),
		.mem_addr(mem_addr),
		.access_width(access_width),
		.access_kind(access_kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.interval_start(interval_start),
		.interval_end(interval_end),
		.end_ip(end_ip),
		.byte_address(byte_address),
		.needs_experiment(needs_experiment),
		.last(last)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[def_use_interval_pruner] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_event(mode, instr_ip, mem_addr, access_width, access_kind);
	end

	// The receiver checks the transfer of this edge, then picks its stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_interval(interval_t'{interval_start, interval_end, end_ip, byte_address,
				needs_experiment, last});
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_style = rx_style_t'($urandom_range(0, 3));
		case (rx_style)
		RX_FREE: out_stall <= 1'b0;
		RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
		RX_PERIODIC: out_stall <= (rx_cycle % 5 < 2);
		default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send_event(code_t m, addr_t ip, addr_t addr, width_t width, code_t kind);
		mode <= m;
		instr_ip <= ip;
		mem_addr <= addr;
		access_width <= width;
		access_kind <= kind;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		// Valid stays high inside a burst so that the next event follows without a gap.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
		end
	endtask

	// Holds the sender until every predicted interval has been seen, then lets an access
	// that produced nothing finish inside the block.
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(index_t idx, word_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, data);
		@(posedge clk);
	endtask

	task automatic configure(word_t base, word_t length, word_t limit);
		write_register(dui_pkg::CFG_REGION_BASE, base);
		write_register(dui_pkg::CFG_REGION_LENGTH, length);
		write_register(dui_pkg::CFG_INSTR_LIMIT, limit);
	endtask

	// Most events land on a small hot area around the window base, so that bytes are
	// touched again and again; a few land anywhere in the window or outside it.
	task automatic random_event();
		int span;
		int hot;
		int off;
		int pick;
		int r;
		code_t m;
		code_t kind;
		addr_t addr;
		width_t width;
		span = (sb.region_length > WINDOW_BYTES) ? WINDOW_BYTES : int'(sb.region_length);
		hot = (span > 40) ? 40 : span;
		if ($urandom_range(0, 7) == 0)
			off = int'($urandom_range(0, span + 3));
		else
			off = int'($urandom_range(0, hot + 7)) - 4;
		addr = sb.region_base + off;
		width = width_t'($urandom_range(1, MAX_ACCESS_BYTES));
		r = int'($urandom_range(0, 9));
		kind = (r < 4) ? dui_pkg::KIND_READ : (r < 8) ? dui_pkg::KIND_WRITE :
			(r == 8) ? KIND_OTHER : KIND_SPARE;
		pick = int'($urandom_range(0, 99));
		if (pick < 35) begin
			m = dui_pkg::MODE_INSTR;
		end else if (pick < 80) begin
			m = dui_pkg::MODE_ACCESS;
		end else if (pick < 92) begin
			m = dui_pkg::MODE_FLUSH;
		end else begin
			m = code_t'($urandom_range(0, 3));
			addr = $urandom;
			width = width_t'($urandom_range(0, 15));
		end
		send_event(m, $urandom, addr, width, kind);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window: a first read, a repeat in the same instruction, zero and
		// oversized widths, other kinds, the unused mode, flushes empty, full and outside.
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0000, 4'd8, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0000, 4'd8, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_INSTR, 32'hFFFF_FFFF, '0, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0004, 4'd4, dui_pkg::KIND_WRITE);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0008, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0000, 4'd15, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0010, 4'd8, KIND_OTHER);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0018, 4'd8, KIND_SPARE);
		send_event(MODE_SPARE, '1, '1, '1, KIND_SPARE);
		send_event(dui_pkg::MODE_INSTR, 32'h1234_5678, '0, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_FLUSH, '0, 32'h0000_0010, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_FLUSH, '0, 32'h0000_0064, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_FLUSH, '0, 32'hFFFF_FFFF, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0FFF, 4'd8, dui_pkg::KIND_WRITE);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'hFFFF_FFFC, 4'd8, dui_pkg::KIND_READ);
		drain_results();

		// Window wrapping past the top of the address space, oversized length, and an
		// instruction limit reached two instructions on.
		configure(32'hFFFF_FFFE, 32'd8191, sb.instr_count + 2);
		write_register(CFG_SPARE, '1);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'hFFFF_FFFC, 4'd8, dui_pkg::KIND_WRITE);
		send_event(dui_pkg::MODE_INSTR, 32'hA5A5_A5A5, '0, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_INSTR, 32'h5A5A_5A5A, '0, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_INSTR, 32'h0F0F_0F0F, '0, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'hFFFF_FFFE, 4'd2, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_FLUSH, '0, 32'hFFFF_FFFF, 4'd0, dui_pkg::KIND_READ);
		drain_results();

		configure(32'h0, 32'h0, 32'h0);
		send_event(dui_pkg::MODE_FLUSH, '0, 32'h0000_0000, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'h0000_0000, 4'd8, dui_pkg::KIND_READ);
		drain_results();

		configure(32'h0, 32'd1, 32'hFFFF_FFFF);
		send_event(dui_pkg::MODE_FLUSH, '0, 32'h0000_0000, 4'd0, dui_pkg::KIND_READ);
		send_event(dui_pkg::MODE_ACCESS, '0, 32'hFFFF_FFFF, 4'd2, dui_pkg::KIND_READ);
		drain_results();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
			0: configure(32'h0, 32'(dui_pkg::LEN_RESET), 32'(dui_pkg::LIMIT_RESET));
			1: configure(32'hFFFF_FFF0, 32'd64, 32'(dui_pkg::LIMIT_RESET));
			2: configure($urandom, $urandom_range(1, WINDOW_BYTES),
				sb.instr_count + $urandom_range(10, 30));
			3: configure(32'hFFFF_FFFF, 32'd8191, 32'(dui_pkg::LIMIT_RESET));
			4: configure($urandom, $urandom_range(8, 300), 32'(dui_pkg::LIMIT_RESET));
			default: configure(32'h0000_0FC0, 32'd200, 32'(dui_pkg::LIMIT_RESET));
			endcase
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				random_event();
				if ($urandom_range(0, 59) == 0)
					drain_results();
			end
			drain_results();
		end

		if (sb.errors == 0)
			$display("[def_use_interval_pruner] OK");
		else
			$display("[def_use_interval_pruner] ERROR");
		$finish;
	end

endmodule
